@@ hdl/vdu_pkg.sv @@
// Package: types, constants and command codes of the vector distance unit
`default_nettype none
package vdu_pkg;

  localparam int unsigned DOT_W  = 42;
  localparam int unsigned SQ_W   = 41;
  localparam int unsigned AD_W   = 28;
  localparam int unsigned SD_W   = 45;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned DEN_W  = 64;
  localparam int unsigned DREM_W = 65;
  localparam int unsigned Q_W    = 18;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] SQ_LAST_STEP  = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(Q_W - 1);

  localparam logic [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
  localparam logic [AD_W-1:0]  AD_MAX  = {AD_W{1'b1}};
  localparam logic [SD_W-1:0]  SD_MAX  = {SD_W{1'b1}};
  localparam logic [Q_W-1:0]   ONE_Q16 = Q_W'(65536);

  typedef enum logic [1:0] {
    MODE_L1  = 2'd0,
    MODE_L2  = 2'd1,
    MODE_COS = 2'd2,
    MODE_BAD = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_SQ_LOAD_SD,
    OP_SQ_LOAD_X,
    OP_SQ_LOAD_Y,
    OP_SQ_STEP,
    OP_MUL,
    OP_DIV_LOAD,
    OP_DIV_STEP
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_L1,
    RES_L2,
    RES_COS,
    RES_BAD_MAX,
    RES_BAD_ZERO
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_EVAL,
    ST_SQ1,
    ST_SQLY,
    ST_SQ2,
    ST_MUL,
    ST_DIVL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t    op;
    logic      out_load;
    res_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  ad_sat;
    logic  sd_sat;
    logic  cos_bad;
  } dp_status_t;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic             bad_result;
  } out_item_t;

endpackage
`default_nettype wire

@@ hdl/vector_distance_unit_top.sv @@
// Top level of the vector distance unit (L1, L2 and cosine metrics)
// Throughput: one element item per cycle while accumulating.
// After the last item: L1 and bad results pass through ST_EVAL and ST_OUT to the output register;
// L2 adds 32 steps of the shared root unit, cosine two 32-step roots, one multiply and
// 18 divide steps. Input is held off until the result is loaded.
// Reset (synchronous, rst_n low) clears the sums, the mode (L1) and the output valid.
`default_nettype none
module vector_distance_unit_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire vdu_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vdu_pkg::out_item_t     out_item,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata
);

  vdu_pkg::dp_cmd_t    cmd;
  vdu_pkg::dp_status_t status;

  vdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last_element),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  vdu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

@@ hdl/vdu_dp.sv @@
// Datapath: running sums, shared square root unit, multiplier and divider
`default_nettype none
module vdu_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_wdata,
  input  wire vdu_pkg::in_item_t in_item,
  input  wire vdu_pkg::dp_cmd_t cmd,
  output vdu_pkg::dp_status_t   status,
  output vdu_pkg::out_item_t    out_item
);

  localparam logic [vdu_pkg::DOT_W:0] DOT_MAX_EXT = {1'b0, vdu_pkg::DOT_MAX};
  localparam logic [vdu_pkg::DOT_W:0] DOT_MIN_EXT = {1'b1, vdu_pkg::DOT_MIN};

  vdu_pkg::mode_t mode_r;

  logic signed [vdu_pkg::DOT_W-1:0] dot_r;
  logic [vdu_pkg::SQ_W-1:0]  xsq_r, ysq_r;
  logic [vdu_pkg::AD_W-1:0]  ad_r;
  logic [vdu_pkg::SD_W-1:0]  sd_r;

  logic [vdu_pkg::RAD_W-1:0]  rad_r, rad_nxt;
  logic [vdu_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [vdu_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [vdu_pkg::ROOT_W-1:0] nx_r;
  logic [vdu_pkg::DEN_W-1:0]  den_r;
  logic [vdu_pkg::DREM_W-1:0] drem_r, drem_nxt;
  logic [vdu_pkg::Q_W-1:0]    q_r, q_nxt;
  logic                       ovf_r;
  logic                       neg_r;

  logic signed [16:0] diff;
  logic [16:0]        adv;
  logic [33:0]        adsq;
  logic signed [31:0] prod;
  logic [31:0]        xx, yy;
  logic signed [vdu_pkg::DOT_W:0] dot_sum;
  logic [vdu_pkg::SQ_W:0]  xsq_sum, ysq_sum;
  logic [vdu_pkg::AD_W:0]  ad_sum;
  logic [vdu_pkg::SD_W:0]  sd_sum;
  logic [vdu_pkg::REM_W-1:0] sq_shift, sq_trial;
  logic [vdu_pkg::DREM_W-1:0] d_shift, d_load;
  logic [vdu_pkg::DOT_W-1:0]  mag;
  logic [vdu_pkg::Q_W-1:0]    sim, cos_dist;
  logic                       clear;

  assign diff    = 17'(in_item.x_value) - 17'(in_item.y_value);
  assign adv     = diff[16] ? 17'(-diff) : 17'(diff);
  assign adsq    = 34'(adv) * 34'(adv);
  assign prod    = 32'(in_item.x_value) * 32'(in_item.y_value);
  assign xx      = 32'(32'(in_item.x_value) * 32'(in_item.x_value));
  assign yy      = 32'(32'(in_item.y_value) * 32'(in_item.y_value));
  assign dot_sum = {dot_r[vdu_pkg::DOT_W-1], dot_r} + (vdu_pkg::DOT_W+1)'(prod);
  assign xsq_sum = {1'b0, xsq_r} + (vdu_pkg::SQ_W+1)'(xx);
  assign ysq_sum = {1'b0, ysq_r} + (vdu_pkg::SQ_W+1)'(yy);
  assign ad_sum  = {1'b0, ad_r} + (vdu_pkg::AD_W+1)'(adv);
  assign sd_sum  = {1'b0, sd_r} + (vdu_pkg::SD_W+1)'(adsq);
  assign clear   = cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vdu_pkg::MODE_L1;
    end else if (cfg_we) begin
      mode_r <= vdu_pkg::mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      dot_r <= '0;
      xsq_r <= '0;
      ysq_r <= '0;
      ad_r  <= '0;
      sd_r  <= '0;
    end else if (cmd.op == vdu_pkg::OP_ACC) begin
      if (dot_sum > $signed({DOT_MAX_EXT[vdu_pkg::DOT_W:0]})) begin
        dot_r <= vdu_pkg::DOT_MAX;
      end else if (dot_sum < $signed({DOT_MIN_EXT[vdu_pkg::DOT_W:0]})) begin
        dot_r <= vdu_pkg::DOT_MIN;
      end else begin
        dot_r <= dot_sum[vdu_pkg::DOT_W-1:0];
      end
      xsq_r <= xsq_sum[vdu_pkg::SQ_W] ? vdu_pkg::SQ_MAX : xsq_sum[vdu_pkg::SQ_W-1:0];
      ysq_r <= ysq_sum[vdu_pkg::SQ_W] ? vdu_pkg::SQ_MAX : ysq_sum[vdu_pkg::SQ_W-1:0];
      ad_r  <= ad_sum[vdu_pkg::AD_W] ? vdu_pkg::AD_MAX : ad_sum[vdu_pkg::AD_W-1:0];
      sd_r  <= sd_sum[vdu_pkg::SD_W] ? vdu_pkg::SD_MAX : sd_sum[vdu_pkg::SD_W-1:0];
    end
  end

  assign status.mode    = mode_r;
  assign status.ad_sat  = (ad_r == vdu_pkg::AD_MAX);
  assign status.sd_sat  = (sd_r == vdu_pkg::SD_MAX);
  assign status.cos_bad = (dot_r == vdu_pkg::DOT_MAX) || (dot_r == vdu_pkg::DOT_MIN) ||
                          (xsq_r == vdu_pkg::SQ_MAX) || (ysq_r == vdu_pkg::SQ_MAX) ||
                          (xsq_r == '0) || (ysq_r == '0);

  assign sq_shift = {rem_r[vdu_pkg::REM_W-3:0], rad_r[vdu_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {(vdu_pkg::REM_W-vdu_pkg::ROOT_W-2)'(0), root_r, 2'b01};
  assign mag      = dot_r[vdu_pkg::DOT_W-1] ? vdu_pkg::DOT_W'(-dot_r) : dot_r;
  assign d_shift  = {drem_r[vdu_pkg::DREM_W-2:0], 1'b0};
  assign d_load   = vdu_pkg::DREM_W'({mag, 20'd0});

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    drem_nxt = drem_r;
    q_nxt    = q_r;
    unique case (cmd.op)
      vdu_pkg::OP_SQ_LOAD_SD: begin
        rad_nxt  = vdu_pkg::RAD_W'({sd_r, 16'd0});
        rem_nxt  = '0;
        root_nxt = '0;
      end
      vdu_pkg::OP_SQ_LOAD_X: begin
        rad_nxt  = vdu_pkg::RAD_W'({xsq_r, 22'd0});
        rem_nxt  = '0;
        root_nxt = '0;
      end
      vdu_pkg::OP_SQ_LOAD_Y: begin
        rad_nxt  = vdu_pkg::RAD_W'({ysq_r, 22'd0});
        rem_nxt  = '0;
        root_nxt = '0;
      end
      vdu_pkg::OP_SQ_STEP: begin
        rad_nxt = {rad_r[vdu_pkg::RAD_W-3:0], 2'b00};
        if (sq_shift >= sq_trial) begin
          rem_nxt  = sq_shift - sq_trial;
          root_nxt = {root_r[vdu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_shift;
          root_nxt = {root_r[vdu_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      vdu_pkg::OP_DIV_LOAD: begin
        drem_nxt = d_load;
        q_nxt    = '0;
      end
      vdu_pkg::OP_DIV_STEP: begin
        if (d_shift >= vdu_pkg::DREM_W'(den_r)) begin
          drem_nxt = d_shift - vdu_pkg::DREM_W'(den_r);
          q_nxt    = {q_r[vdu_pkg::Q_W-2:0], 1'b1};
        end else begin
          drem_nxt = d_shift;
          q_nxt    = {q_r[vdu_pkg::Q_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    drem_r <= drem_nxt;
    q_r    <= q_nxt;
    if (cmd.op == vdu_pkg::OP_SQ_LOAD_Y) begin
      nx_r <= root_r;
    end
    if (cmd.op == vdu_pkg::OP_MUL) begin
      den_r <= vdu_pkg::DEN_W'(nx_r) * vdu_pkg::DEN_W'(root_r);
    end
    if (cmd.op == vdu_pkg::OP_DIV_LOAD) begin
      ovf_r <= (d_load >= vdu_pkg::DREM_W'(den_r));
      neg_r <= dot_r[vdu_pkg::DOT_W-1];
    end
  end

  assign sim      = (ovf_r || q_r > vdu_pkg::ONE_Q16) ? vdu_pkg::ONE_Q16 : q_r;
  assign cos_dist = neg_r ? vdu_pkg::ONE_Q16 + sim : vdu_pkg::ONE_Q16 - sim;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.kind)
        vdu_pkg::RES_L1: begin
          out_item.distance   <= vdu_pkg::OUT_W'({ad_r, 8'd0});
          out_item.bad_result <= 1'b0;
        end
        vdu_pkg::RES_L2: begin
          out_item.distance   <= vdu_pkg::OUT_W'(root_r);
          out_item.bad_result <= 1'b0;
        end
        vdu_pkg::RES_COS: begin
          out_item.distance   <= vdu_pkg::OUT_W'(cos_dist);
          out_item.bad_result <= 1'b0;
        end
        vdu_pkg::RES_BAD_MAX: begin
          out_item.distance   <= {vdu_pkg::OUT_W{1'b1}};
          out_item.bad_result <= 1'b1;
        end
        default: begin
          out_item.distance   <= '0;
          out_item.bad_result <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/vdu_ctrl.sv @@
// Controller: state machine that sequences accumulation, root, divide and result
`default_nettype none
module vdu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire vdu_pkg::dp_status_t status,
  output vdu_pkg::dp_cmd_t        cmd
);

  vdu_pkg::state_t    state_r, state_nxt;
  vdu_pkg::res_kind_t kind_r, kind_nxt;
  logic [vdu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdu_pkg::ST_ACC;
      kind_r      <= vdu_pkg::RES_L1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = vdu_pkg::OP_NONE;
    cmd.out_load  = 1'b0;
    cmd.kind      = kind_r;
    unique case (state_r)
      vdu_pkg::ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = vdu_pkg::OP_ACC;
          if (in_last) begin
            state_nxt = vdu_pkg::ST_EVAL;
          end
        end
      end
      vdu_pkg::ST_EVAL: begin
        cnt_nxt = '0;
        unique case (status.mode)
          vdu_pkg::MODE_L1: begin
            kind_nxt  = status.ad_sat ? vdu_pkg::RES_BAD_MAX : vdu_pkg::RES_L1;
            state_nxt = vdu_pkg::ST_OUT;
          end
          vdu_pkg::MODE_L2: begin
            if (status.sd_sat) begin
              kind_nxt  = vdu_pkg::RES_BAD_MAX;
              state_nxt = vdu_pkg::ST_OUT;
            end else begin
              kind_nxt  = vdu_pkg::RES_L2;
              cmd.op    = vdu_pkg::OP_SQ_LOAD_SD;
              state_nxt = vdu_pkg::ST_SQ1;
            end
          end
          vdu_pkg::MODE_COS: begin
            if (status.cos_bad) begin
              kind_nxt  = vdu_pkg::RES_BAD_ZERO;
              state_nxt = vdu_pkg::ST_OUT;
            end else begin
              kind_nxt  = vdu_pkg::RES_COS;
              cmd.op    = vdu_pkg::OP_SQ_LOAD_X;
              state_nxt = vdu_pkg::ST_SQ1;
            end
          end
          default: begin
            kind_nxt  = vdu_pkg::RES_BAD_ZERO;
            state_nxt = vdu_pkg::ST_OUT;
          end
        endcase
      end
      vdu_pkg::ST_SQ1: begin
        cmd.op  = vdu_pkg::OP_SQ_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == vdu_pkg::SQ_LAST_STEP) begin
          state_nxt = (kind_r == vdu_pkg::RES_L2) ? vdu_pkg::ST_OUT : vdu_pkg::ST_SQLY;
        end
      end
      vdu_pkg::ST_SQLY: begin
        cmd.op    = vdu_pkg::OP_SQ_LOAD_Y;
        cnt_nxt   = '0;
        state_nxt = vdu_pkg::ST_SQ2;
      end
      vdu_pkg::ST_SQ2: begin
        cmd.op  = vdu_pkg::OP_SQ_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == vdu_pkg::SQ_LAST_STEP) begin
          state_nxt = vdu_pkg::ST_MUL;
        end
      end
      vdu_pkg::ST_MUL: begin
        cmd.op    = vdu_pkg::OP_MUL;
        state_nxt = vdu_pkg::ST_DIVL;
      end
      vdu_pkg::ST_DIVL: begin
        cmd.op    = vdu_pkg::OP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = vdu_pkg::ST_DIV;
      end
      vdu_pkg::ST_DIV: begin
        cmd.op  = vdu_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == vdu_pkg::DIV_LAST_STEP) begin
          state_nxt = vdu_pkg::ST_OUT;
        end
      end
      vdu_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = vdu_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = vdu_pkg::ST_ACC;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/vdu_checker.sv @@
// Port checker for the vector distance unit, bound to the top level
`default_nettype none
module vdu_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire vdu_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire vdu_pkg::out_item_t out_item
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item dropped or changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.last_element |=> !in_ready)
    else $error("item taken while a result is being computed");

  a_no_result_mid_vector: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_item.last_element |=> !$rose(out_valid))
    else $error("result item without a last item");

endmodule

bind vector_distance_unit_top vdu_checker u_vdu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

@@ tb/vdu_checker.sv @@
// Checker: watches the item channels, predicts distances and compares results
module vdu_tb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  vdu_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  vdu_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  output int                 err_count,
  output int                 pending,
  output int                 items_seen,
  output int                 results_seen
);

  localparam longint DOT_HI = (longint'(1) <<< 41) - 1;
  localparam longint DOT_LO = -DOT_HI - 1;
  localparam logic [63:0] SQ_LIM = (64'd1 << 41) - 1;
  localparam logic [63:0] AD_LIM = (64'd1 << 28) - 1;
  localparam logic [63:0] SD_LIM = (64'd1 << 45) - 1;
  localparam logic [63:0] ONE    = 64'd65536;

  vdu_pkg::mode_t     metric;
  longint             dot_acc;
  logic [63:0]        xsq_acc, ysq_acc, ad_acc, sd_acc;
  vdu_pkg::out_item_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, cand;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] s, logic [63:0] v, logic [63:0] lim);
    logic [63:0] t;
    t = s + v;
    return (t > lim) ? lim : t;
  endfunction

  function automatic vdu_pkg::out_item_t distance_of();
    vdu_pkg::out_item_t r;
    logic [63:0]        nx, ny, den, mag;
    logic [127:0]       sim;
    r = '0;
    case (metric)
      vdu_pkg::MODE_L1: begin
        if (ad_acc == AD_LIM) r = '{distance: '1, bad_result: 1'b1};
        else r.distance = vdu_pkg::OUT_W'(ad_acc << 8);
      end
      vdu_pkg::MODE_L2: begin
        if (sd_acc == SD_LIM) r = '{distance: '1, bad_result: 1'b1};
        else r.distance = vdu_pkg::OUT_W'(int_root(sd_acc << 16));
      end
      vdu_pkg::MODE_COS: begin
        if (dot_acc == DOT_HI || dot_acc == DOT_LO || xsq_acc == SQ_LIM ||
            ysq_acc == SQ_LIM || xsq_acc == 0 || ysq_acc == 0) begin
          r.bad_result = 1'b1;
        end else begin
          nx  = int_root(xsq_acc << 22);
          ny  = int_root(ysq_acc << 22);
          den = nx * ny;
          mag = (dot_acc < 0) ? 64'(-dot_acc) : 64'(dot_acc);
          sim = (128'(mag) << 38) / 128'(den);
          if (sim > 128'(ONE)) sim = 128'(ONE);
          r.distance = (dot_acc < 0) ? vdu_pkg::OUT_W'(ONE + 64'(sim))
                                     : vdu_pkg::OUT_W'(ONE - 64'(sim));
        end
      end
      default: r.bad_result = 1'b1;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    longint             x, y, d;
    logic [63:0]        ad;
    vdu_pkg::out_item_t exp_item;
    if (!rst_n) begin
      metric  <= vdu_pkg::MODE_L1;
      dot_acc = 0; xsq_acc = 0; ysq_acc = 0; ad_acc = 0; sd_acc = 0;
      expected_q.delete();
      err_count    <= 0;
      items_seen   <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) metric <= vdu_pkg::mode_t'(cfg_wdata);
      if (in_valid && in_ready) begin
        items_seen <= items_seen + 1;
        x  = longint'(in_item.x_value);
        y  = longint'(in_item.y_value);
        d  = x - y;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        dot_acc = dot_acc + x * y;
        if (dot_acc > DOT_HI) dot_acc = DOT_HI;
        if (dot_acc < DOT_LO) dot_acc = DOT_LO;
        xsq_acc = sat_add(xsq_acc, 64'(x * x), SQ_LIM);
        ysq_acc = sat_add(ysq_acc, 64'(y * y), SQ_LIM);
        ad_acc  = sat_add(ad_acc, ad, AD_LIM);
        sd_acc  = sat_add(sd_acc, ad * ad, SD_LIM);
        if (in_item.last_element) begin
          expected_q = {expected_q, distance_of()};
          dot_acc = 0; xsq_acc = 0; ysq_acc = 0; ad_acc = 0; sd_acc = 0;
        end
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (err_count < 10) $display("unexpected result %p", out_item);
          err_count <= err_count + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.distance !== out_item.distance ||
              exp_item.bad_result !== out_item.bad_result) begin
            if (err_count < 10)
              $display("mismatch: expected dist %0d bad %0b, got dist %0d bad %0b",
                       exp_item.distance, exp_item.bad_result,
                       out_item.distance, out_item.bad_result);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_vector_distance_unit_top.sv @@
// Testbench top: stimulus, idling and verdict for the vector distance unit
module tb_vector_distance_unit_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  vdu_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  vdu_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_wdata = '0;
  int                 err_count, pending, items_seen, results_seen;
  int                 send_idle_pct = 0, recv_idle_pct = 0;
  int                 cycles = 0;
  int                 sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vector_distance_unit_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item, .cfg_we, .cfg_wdata
  );

  vdu_tb_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item, .cfg_we, .cfg_wdata,
    .err_count, .pending, .items_seen, .results_seen
  );

  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(logic [15:0] x, logic [15:0] y, logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{x_value: x, y_value: y, last_element: last};
    @(posedge clk iff in_ready);
    sent++;
  endtask

  // drain results and let the block settle before touching the mode
  task automatic set_mode(vdu_pkg::mode_t m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(int len);
    for (int i = 0; i < len; i++) send(rand_val(), rand_val(), i == len - 1);
  endtask

  initial begin
    int budget;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every metric, zero norm and unused mode
    send(16'h7fff, 16'h8000, 1'b1);
    send(16'h0100, 16'h0100, 1'b0);
    send(16'hffff, 16'h0000, 1'b1);
    set_mode(vdu_pkg::MODE_L2);
    send(16'h8000, 16'h7fff, 1'b0);
    send(16'h0000, 16'h0000, 1'b1);
    send(16'h0300, 16'h0000, 1'b0);
    send(16'h0000, 16'h0400, 1'b1);
    set_mode(vdu_pkg::MODE_COS);
    send(16'h0100, 16'h0200, 1'b0);
    send(16'h0200, 16'h0400, 1'b1);
    send(16'h7fff, 16'h8000, 1'b1);
    send(16'h0000, 16'h0100, 1'b1);
    send(16'h0100, 16'h0000, 1'b1);
    send(16'h0100, 16'hff00, 1'b0);
    send(16'hff00, 16'h0100, 1'b1);
    send(16'h0001, 16'h0001, 1'b1);
    send(16'h0001, 16'hffff, 1'b1);
    set_mode(vdu_pkg::MODE_BAD);
    send(16'h1234, 16'h4321, 1'b1);

    // random vectors under each idling pattern and every mode
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 19 : 0;
      for (int m = 0; m < 4; m++) begin
        set_mode(vdu_pkg::mode_t'(m));
        budget = sent + 108;
        while (sent < budget)
          send_vector(($urandom_range(40) == 0) ? 64 : $urandom_range(1, 12));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("run covered %0d items and %0d results over all metrics and idling patterns",
             items_seen, results_seen);
    $display("including extreme elements, zero norms and the unused mode");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
